[hw/rtl/smmt_pkg.sv]
// Shared constants, types and the control program of the small matrix engine.
`default_nettype none

package smmt_pkg;

    // Geometry
    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Field widths
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int RES_W     = 35;
    localparam int RC_W      = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // Operations
    localparam logic [OP_W-1:0] OP_SUB  = 2'd0;
    localparam logic [OP_W-1:0] OP_MUL  = 2'd1;
    localparam logic [OP_W-1:0] OP_TRN  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // Program addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_SUB_RD = 3'd0;
    localparam logic [PC_W-1:0] PC_SUB_EM = 3'd1;
    localparam logic [PC_W-1:0] PC_MUL_RD = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL_MP = 3'd3;
    localparam logic [PC_W-1:0] PC_MUL_AC = 3'd4;
    localparam logic [PC_W-1:0] PC_MUL_EM = 3'd5;
    localparam logic [PC_W-1:0] PC_TRN_RD = 3'd6;
    localparam logic [PC_W-1:0] PC_TRN_EM = 3'd7;

    // A read address select
    localparam logic [1:0] A_IJ = 2'd0;
    localparam logic [1:0] A_IK = 2'd1;
    localparam logic [1:0] A_JI = 2'd2;

    // B read address select
    localparam logic B_IJ = 1'b0;
    localparam logic B_KJ = 1'b1;

    // Accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_CLR  = 2'd2;

    // Result value select
    localparam logic [1:0] VAL_DIFF = 2'd0;
    localparam logic [1:0] VAL_ACC  = 2'd1;
    localparam logic [1:0] VAL_A    = 2'd2;

    // Jump condition
    localparam logic [1:0] J_NEXT    = 2'd0;
    localparam logic [1:0] J_KMORE   = 2'd1;
    localparam logic [1:0] J_RESMORE = 2'd2;

    typedef struct packed {
        logic [1:0]      a_sel;
        logic            b_sel;
        logic [1:0]      acc_op;
        logic            inc_k;
        logic            emit;
        logic [1:0]      val_sel;
        logic [1:0]      jcond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Control store: one word per program step
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            PC_SUB_RD: w = '{A_IJ, B_IJ, ACC_HOLD, 1'b0, 1'b0, VAL_DIFF, J_NEXT,    PC_SUB_RD};
            PC_SUB_EM: w = '{A_IJ, B_IJ, ACC_HOLD, 1'b0, 1'b1, VAL_DIFF, J_RESMORE, PC_SUB_RD};
            PC_MUL_RD: w = '{A_IK, B_KJ, ACC_HOLD, 1'b0, 1'b0, VAL_ACC,  J_NEXT,    PC_MUL_RD};
            PC_MUL_MP: w = '{A_IK, B_KJ, ACC_HOLD, 1'b0, 1'b0, VAL_ACC,  J_NEXT,    PC_MUL_RD};
            PC_MUL_AC: w = '{A_IK, B_KJ, ACC_ADD,  1'b1, 1'b0, VAL_ACC,  J_KMORE,   PC_MUL_RD};
            PC_MUL_EM: w = '{A_IK, B_KJ, ACC_CLR,  1'b0, 1'b1, VAL_ACC,  J_RESMORE, PC_MUL_RD};
            PC_TRN_RD: w = '{A_JI, B_IJ, ACC_HOLD, 1'b0, 1'b0, VAL_A,    J_NEXT,    PC_TRN_RD};
            PC_TRN_EM: w = '{A_JI, B_IJ, ACC_HOLD, 1'b0, 1'b1, VAL_A,    J_RESMORE, PC_TRN_RD};
            default:   w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/smmt_if.sv]
// Valid/ready channel interfaces for element loads and results.
`default_nettype none

interface smmt_in_if
    import smmt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] elem_value;
    logic                    to_matrix_b;
    logic [RC_W-1:0]         elem_row;
    logic [RC_W-1:0]         elem_col;
    logic                    load_done;

    modport source (
        output valid, elem_value, to_matrix_b, elem_row, elem_col, load_done,
        input  ready
    );
    modport sink (
        input  valid, elem_value, to_matrix_b, elem_row, elem_col, load_done,
        output ready
    );
endinterface

interface smmt_out_if
    import smmt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic [RC_W-1:0]         result_row;
    logic [RC_W-1:0]         result_col;
    logic                    result_last;

    modport source (
        output valid, result_value, result_row, result_col, result_last,
        input  ready
    );
    modport sink (
        input  valid, result_value, result_row, result_col, result_last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/small_matrix_sub_mul_transpose.sv]
// Small matrix engine top level: element loads, microcoded subtract/multiply/transpose.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        elem_value, to_matrix_b, elem_row, elem_col, load_done
//  o_out     out  valid/ready        result_value, result_row, result_col, result_last
//  cfg       in   i_cfg_wr_en only   i_cfg_idx, i_cfg_data
//
// A transfer with load_done starts the program (not for the unused operation) and no new
// load is taken until its last result sits in the output register. Subtract and transpose
// read the store, then emit, per result; multiply reads, multiplies and accumulates
// per column in the single shared multiply-accumulate loop, then emits. Reset clears the
// controller, configuration and store valid bits, so both matrices read as zero (no
// clearing pass). A full output register with ready low holds the program on its emit step.
`default_nettype none

module small_matrix_sub_mul_transpose
    import smmt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    smmt_in_if.sink                   i_in,
    smmt_out_if.source                o_out,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    // Configuration
    logic [OP_W-1:0]  r_op;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;

    // Sequencer and datapath
    logic             r_busy;
    logic [PC_W-1:0]  r_pc;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RES_W-1:0]  r_acc;

    // Output register
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_out_value;
    logic [RC_W-1:0]         r_out_row;
    logic [RC_W-1:0]         r_out_col;
    logic                    r_out_last;

    t_uword                  uw;
    logic                    in_fire;
    logic                    start;
    logic                    stall;
    logic                    go;
    logic [DIM_W-1:0]        nr;
    logic [DIM_W-1:0]        nc;
    logic [DIM_W-1:0]        outer_lim;
    logic [DIM_W-1:0]        inner_lim;
    logic                    k_last;
    logic                    j_last;
    logic                    i_last;
    logic                    res_last;
    logic [ADDR_W-1:0]       a_addr;
    logic [ADDR_W-1:0]       b_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_ok;
    logic signed [VAL_W-1:0] a_val;
    logic signed [VAL_W-1:0] b_val;
    logic signed [VAL_W:0]   diff;
    logic signed [RES_W-1:0] emit_val;
    logic [PC_W-1:0]         entry_pc;

    assign uw      = uc_rom(r_pc);
    assign in_fire = i_in.valid && i_in.ready;
    assign start   = in_fire && i_in.load_done && (r_op != OP_NONE);

    // Hold the program on an emit step while the previous result waits
    assign stall = uw.emit && r_out_valid && !o_out.ready;
    assign go    = r_busy && !stall;

    assign nr        = clamp_dim(r_rows);
    assign nc        = clamp_dim(r_cols);
    assign outer_lim = (r_op == OP_TRN) ? nc : nr;
    assign inner_lim = (r_op == OP_TRN) ? nr : nc;

    assign k_last   = (DIM_W'(r_k) + DIM_W'(1)) == nc;
    assign j_last   = (DIM_W'(r_j) + DIM_W'(1)) == inner_lim;
    assign i_last   = (DIM_W'(r_i) + DIM_W'(1)) == outer_lim;
    assign res_last = i_last && j_last;

    always_comb begin
        case (uw.a_sel)
            A_IK:    a_addr = {r_i, r_k};
            A_JI:    a_addr = {r_j, r_i};
            default: a_addr = {r_i, r_j};
        endcase
        b_addr = (uw.b_sel == B_KJ) ? {r_k, r_j} : {r_i, r_j};
    end

    // Drop loads whose position lies outside the store
    assign wr_addr = {IDX_W'(i_in.elem_row), IDX_W'(i_in.elem_col)};
    assign wr_ok   = in_fire && (int'(i_in.elem_row) < MAX_DIM)
                             && (int'(i_in.elem_col) < MAX_DIM);

    smmt_store u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_ok && !i_in.to_matrix_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.elem_value),
        .i_rd_addr (a_addr),
        .o_rd_data (a_val)
    );

    smmt_store u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_ok && i_in.to_matrix_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.elem_value),
        .i_rd_addr (b_addr),
        .o_rd_data (b_val)
    );

    assign diff = (VAL_W+1)'(a_val) - (VAL_W+1)'(b_val);

    always_comb begin
        case (uw.val_sel)
            VAL_DIFF: emit_val = RES_W'(diff);
            VAL_ACC:  emit_val = r_acc;
            VAL_A:    emit_val = RES_W'(a_val);
            default:  emit_val = '0;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_SUB:  entry_pc = PC_SUB_RD;
            OP_MUL:  entry_pc = PC_MUL_RD;
            default: entry_pc = PC_TRN_RD;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_SUB;
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_OPERATION: r_op   <= OP_W'(i_cfg_data);
                CFG_ROWS:      r_rows <= i_cfg_data;
                CFG_COLS:      r_cols <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Step counter, loop counters and jumps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_SUB_RD;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
        end else if (!r_busy) begin
            if (start) begin
                r_busy <= 1'b1;
                r_pc   <= entry_pc;
                r_i    <= '0;
                r_j    <= '0;
                r_k    <= '0;
            end
        end else if (go) begin
            if (uw.emit) begin
                r_k <= '0;
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end else if (uw.inc_k) begin
                r_k <= r_k + IDX_W'(1);
            end
            case (uw.jcond)
                J_KMORE:   r_pc <= k_last ? r_pc + PC_W'(1) : uw.target;
                J_RESMORE: begin
                    if (res_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_pc <= uw.target;
                    end
                end
                default:   r_pc <= r_pc + PC_W'(1);
            endcase
        end
    end

    // Multiply and accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= a_val * b_val;
        if (start) begin
            r_acc <= '0;
        end else if (go) begin
            case (uw.acc_op)
                ACC_ADD: r_acc <= r_acc + RES_W'(r_prod);
                ACC_CLR: r_acc <= '0;
                default: ;
            endcase
        end
    end

    // Output register: advance on emit, drop valid once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && uw.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && uw.emit) begin
            r_out_value <= emit_val;
            r_out_row   <= RC_W'(r_i);
            r_out_col   <= RC_W'(r_j);
            r_out_last  <= res_last;
        end
    end

    assign i_in.ready         = !r_busy;
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.result_row   = r_out_row;
    assign o_out.result_col   = r_out_col;
    assign o_out.result_last  = r_out_last;

`ifndef SYNTHESIS
    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_out_valid && r_out_last))
        else $error("program ended without a last result in the output register");

    a_out_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result loaded while no program was running");

    a_start_valid_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ($past(r_op) != OP_NONE))
        else $error("program started for the unused operation");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && $past(r_busy) && $past(go) && ($past(r_pc) == PC_MUL_EM))
        |-> (r_acc == '0))
        else $error("accumulator not cleared after a multiply result");
`endif

endmodule

`default_nettype wire

[hw/rtl/smmt_store.sv]
// Matrix element store: one write port, one registered read port, zero until written.
`default_nettype none

module smmt_store
    import smmt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [ADDR_W-1:0]       i_wr_addr,
    input  wire logic [VAL_W-1:0]        i_wr_data,
    input  wire logic [ADDR_W-1:0]       i_rd_addr,
    output      logic signed [VAL_W-1:0] o_rd_data
);

    logic [VAL_W-1:0]       r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [VAL_W-1:0]       r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Entry valid bits stand in for clearing the array at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? $signed(r_rd_data) : '0;

endmodule

`default_nettype wire

[dv/smmt_tb_pkg.sv]
// Element and result types plus the scoreboard that predicts matrix engine results.
`default_nettype none

package smmt_tb_pkg;
    import smmt_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    to_b;
        logic [RC_W-1:0]         row;
        logic [RC_W-1:0]         col;
        logic                    done;
    } t_elem_load;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic [RC_W-1:0]         row;
        logic [RC_W-1:0]         col;
        logic                    last;
    } t_matrix_result;

    class matrix_result_book;
        logic signed [VAL_W-1:0] mat_a [MAX_DIM][MAX_DIM];
        logic signed [VAL_W-1:0] mat_b [MAX_DIM][MAX_DIM];
        logic [OP_W-1:0]         op_reg;
        logic [CFG_W-1:0]        rows_reg;
        logic [CFG_W-1:0]        cols_reg;
        t_matrix_result          due_results[$];
        int unsigned             mismatches;

        function new();
            foreach (mat_a[r, c]) begin
                mat_a[r][c] = '0;
                mat_b[r][c] = '0;
            end
            op_reg     = OP_SUB;
            rows_reg   = DIM_RESET;
            cols_reg   = DIM_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OPERATION: op_reg = data[OP_W-1:0];
                CFG_ROWS:      rows_reg = data;
                CFG_COLS:      cols_reg = data;
                default:       ;
            endcase
        endfunction

        function int unsigned dim_of(logic [CFG_W-1:0] d);
            if (d == 0)
                return 1;
            if (d > MAX_DIM)
                return MAX_DIM;
            return d;
        endfunction

        function void queue_result(longint v, int unsigned r, int unsigned c);
            t_matrix_result e;
            e.value = v[RES_W-1:0];
            e.row   = r[RC_W-1:0];
            e.col   = c[RC_W-1:0];
            e.last  = 1'b0;
            due_results.push_back(e);
        endfunction

        // Store the element, then on a done flag expand the whole job.
        function void note_load(t_elem_load ld);
            int unsigned nr;
            int unsigned nc;
            int unsigned first;
            longint      acc;
            if (ld.to_b)
                mat_b[ld.row][ld.col] = ld.value;
            else
                mat_a[ld.row][ld.col] = ld.value;
            if (!ld.done)
                return;
            nr    = dim_of(rows_reg);
            nc    = dim_of(cols_reg);
            first = due_results.size();
            case (op_reg)
                OP_SUB: begin
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++)
                            queue_result(longint'(mat_a[i][j]) - longint'(mat_b[i][j]), i, j);
                end
                OP_MUL: begin
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++) begin
                            acc = 0;
                            for (int k = 0; k < nc; k++)
                                acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
                            queue_result(acc, i, j);
                        end
                end
                OP_TRN: begin
                    for (int i = 0; i < nc; i++)
                        for (int j = 0; j < nr; j++)
                            queue_result(longint'(mat_a[j][i]), i, j);
                end
                default: ;
            endcase
            if (due_results.size() > first)
                due_results[$].last = 1'b1;
        endfunction

        function int unsigned due_count();
            return due_results.size();
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        task check_result(t_matrix_result got);
            t_matrix_result want;
            if (due_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %0d at (%0d,%0d) last %0b",
                                        got.value, got.row, got.col, got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.value !== want.value)
                flag_mismatch($sformatf("value at (%0d,%0d): got %0d, want %0d",
                                        want.row, want.col, got.value, want.value));
            if (got.row !== want.row)
                flag_mismatch($sformatf("row: got %0d, want %0d", got.row, want.row));
            if (got.col !== want.col)
                flag_mismatch($sformatf("col: got %0d, want %0d", got.col, want.col));
            if (got.last !== want.last)
                flag_mismatch($sformatf("last at (%0d,%0d): got %0b, want %0b",
                                        want.row, want.col, got.last, want.last));
        endtask
    endclass

endpackage

`default_nettype wire

[dv/tb_small_matrix_sub_mul_transpose.sv]
// Self-checking bench for the small matrix engine: directed jobs, then random jobs.
`default_nettype none

module tb_small_matrix_sub_mul_transpose;
    import smmt_pkg::*;
    import smmt_tb_pkg::*;

    localparam int unsigned ITEM_TARGET   = 300;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    // Margin sized for the slowest result, a multiply over 8 columns.
    localparam int unsigned SETTLE_CYCLES = 32;
    // Register index that maps to nothing; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    smmt_in_if  in_ch ();
    smmt_out_if out_ch ();

    small_matrix_sub_mul_transpose i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    matrix_result_book book;
    bit                calm;        // high: neither side idles nor stalls
    int unsigned       items_sent;
    int unsigned       load_span;   // biases load positions into the used area
    int unsigned       cycles;

    // Period of 2 time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up on a hung run: count cycles and end with a failure at the limit.
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_small_matrix_sub_mul_transpose: errors");
        $finish;
    end

    // Result side back-pressure: stall about a third of the cycles unless calm.
    initial begin : result_ready
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin : watch_results
        t_matrix_result seen;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.value = out_ch.result_value;
            seen.row   = out_ch.result_row;
            seen.col   = out_ch.result_col;
            seen.last  = out_ch.result_last;
            book.check_result(seen);
        end
    end

    // Offer one load, with random idle cycles ahead of it, and hold it until the
    // transfer. Valid stays high on return so back-to-back loads need no toggle.
    task automatic send_load(input t_elem_load ld);
        while (!calm && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.elem_value  <= ld.value;
        in_ch.to_matrix_b <= ld.to_b;
        in_ch.elem_row    <= ld.row;
        in_ch.elem_col    <= ld.col;
        in_ch.load_done   <= ld.done;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        book.note_load(ld);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_elem(input int value, input bit to_b, input int unsigned row,
                             input int unsigned col, input bit done);
        t_elem_load ld;
        ld.value = value[VAL_W-1:0];
        ld.to_b  = to_b;
        ld.row   = row[RC_W-1:0];
        ld.col   = col[RC_W-1:0];
        ld.done  = done;
        send_load(ld);
    endtask

    // Random load: mostly inside the used area, sometimes anywhere, with extremes mixed in.
    task automatic random_load(input bit done);
        int          value;
        int unsigned row;
        int unsigned col;
        case ($urandom_range(15))
            0:       value = -32768;
            1:       value = 32767;
            2:       value = -1;
            3:       value = 0;
            default: value = int'($urandom);
        endcase
        row = ($urandom_range(99) < 75) ? $urandom_range(load_span - 1)
                                        : $urandom_range(MAX_DIM - 1);
        col = ($urandom_range(99) < 75) ? $urandom_range(load_span - 1)
                                        : $urandom_range(MAX_DIM - 1);
        load_elem(value, $urandom_range(1), row, col, done);
    endtask

    // Drop valid and hold until every expected result is in and the engine is quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (book.due_count() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        book.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Reconfigure only once the engine is idle.
    task automatic write_cfg(input logic [CFG_W-1:0] op_data, input logic [CFG_W-1:0] rows_d,
                             input logic [CFG_W-1:0] cols_d, input bit touch_spare);
        settle();
        if (touch_spare)
            write_reg(CFG_SPARE, CFG_W'($urandom));
        write_reg(CFG_OPERATION, op_data);
        write_reg(CFG_ROWS, rows_d);
        write_reg(CFG_COLS, cols_d);
        i_cfg_wr_en <= 1'b0;
        load_span = book.dim_of(rows_d) > book.dim_of(cols_d) ? book.dim_of(rows_d)
                                                               : book.dim_of(cols_d);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return '0;                                   // counts as one
            1:       return CFG_W'($urandom_range(15, MAX_DIM + 1)); // counts as the maximum
            2, 3:    return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom_range(4, 1));
        endcase
    endfunction

    initial begin : stimulus
        logic [OP_W-1:0] op;
        int unsigned     phase;
        int unsigned     pick;
        book       = new();
        calm       = 1'b0;
        items_sent = 0;
        load_span  = MAX_DIM;

        // Drive every input known from time zero; hold reset, then release it.
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.elem_value  <= '0;
        in_ch.to_matrix_b <= 1'b0;
        in_ch.elem_row    <= '0;
        in_ch.elem_col    <= '0;
        in_ch.load_done   <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_idx         <= CFG_OPERATION;
        i_cfg_data        <= '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Subtract over the reset dimensions: widest differences at the corners,
        // every other entry apart from (3,4) still reads as cleared.
        load_elem(32767, 1'b0, 0, 0, 1'b0);
        load_elem(-32768, 1'b1, 0, 0, 1'b0);
        load_elem(-32768, 1'b0, 7, 7, 1'b0);
        load_elem(32767, 1'b1, 7, 7, 1'b0);
        load_elem(-1, 1'b0, 3, 4, 1'b1);

        // Multiply 8x8 with extreme products summed into one entry.
        write_cfg({2'b00, OP_MUL}, CFG_W'(8), CFG_W'(8), 1'b0);
        load_elem(-32768, 1'b0, 0, 7, 1'b0);
        load_elem(-32768, 1'b1, 7, 0, 1'b1);

        // Transpose of a non-square 3x5 region.
        write_cfg({2'b00, OP_TRN}, CFG_W'(3), CFG_W'(5), 1'b0);
        load_elem(1234, 1'b0, 2, 4, 1'b1);

        // Unused operation: the stores still update but no results appear.
        write_cfg({2'b11, OP_NONE}, CFG_W'(8), CFG_W'(8), 1'b1);
        load_elem(555, 1'b1, 5, 5, 1'b0);
        load_elem(-2, 1'b0, 1, 1, 1'b1);

        // Dimensions out of range clamp to one and to the maximum.
        write_cfg({2'b00, OP_SUB}, '0, CFG_W'(15), 1'b0);
        load_elem(21845, 1'b1, 0, 3, 1'b1);
        write_cfg({2'b00, OP_MUL}, CFG_W'(15), '0, 1'b0);
        load_elem(-21846, 1'b0, 6, 0, 1'b1);
        write_cfg({2'b10, OP_TRN}, CFG_W'(9), CFG_W'(1), 1'b1);
        load_elem(7, 1'b0, 0, 6, 1'b1);
        write_cfg({2'b01, OP_SUB}, CFG_W'(1), CFG_W'(1), 1'b0);
        load_elem(0, 1'b0, 0, 0, 1'b1);

        // Random phases: each reconfigures, then runs a few jobs of loads, most ending in done.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            pick = $urandom_range(99);
            op   = pick < 30 ? OP_SUB : pick < 60 ? OP_MUL : pick < 92 ? OP_TRN : OP_NONE;
            write_cfg({2'($urandom), op}, pick_dim(), pick_dim(), $urandom_range(9) == 0);
            // A long stretch with no idling on either side.
            calm = (phase >= 5 && phase < 10);
            repeat ($urandom_range(4, 1)) begin
                repeat ($urandom_range(8)) random_load(1'b0);
                // Now and then leave a job open so its loads run into the next one.
                if ($urandom_range(9) != 0)
                    random_load(1'b1);
                // Now and then hold the sender until every result of the job has come back.
                if ($urandom_range(7) == 0)
                    settle();
            end
        end
        calm = 1'b0;

        settle();
        if (book.mismatches == 0)
            $display("tb_small_matrix_sub_mul_transpose: clean");
        else
            $display("tb_small_matrix_sub_mul_transpose: errors");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/smmt_pkg.sv
hw/rtl/smmt_if.sv
hw/rtl/smmt_store.sv
hw/rtl/small_matrix_sub_mul_transpose.sv
dv/smmt_tb_pkg.sv
dv/tb_small_matrix_sub_mul_transpose.sv
